FILE: sv/ttb_pkg.sv
package ttb_pkg;

  localparam int PosW    = 32;
  localparam int TexW    = 24;
  localparam int OutW    = 32;
  localparam int FracSh  = 17;
  localparam int EdgeW   = PosW + 1;
  localparam int DeltaW  = TexW + 1;
  localparam int ProdW   = EdgeW + DeltaW;
  localparam int AccW    = ProdW + 1;
  localparam int DsorW   = AccW + 1;
  localparam int DivdW   = AccW + FracSh + 1;
  localparam int QuoW    = OutW + 1;
  localparam int HiW     = DivdW - QuoW;
  localparam int CntW    = $clog2(QuoW);
  localparam int NumAxis = 3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_EVAL,
    S_PREP,
    S_CHK,
    S_DIV,
    S_FIN,
    S_LOAD
  } ttb_state_t;

endpackage

FILE: sv/triangle_tangent_basis.sv
// channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// input    | in_valid / in_stall   | pos_x pos_y pos_z (Q16.16), tex_u tex_v (Q8.16)
// output   | out_valid / out_stall | tangent_*, bitangent_* (Q16.16), degenerate, clipped
//
// first and second corners of a triangle are only stored; third corner: one shared
// 33x25 multiplier and one restoring divider; determinant (3 multiply, evaluate), then
// each of six components (3 multiply, evaluate, prep, check, divide steps skipped on
// overflow, finish), then the load state; a zero determinant goes straight to load
// in_stall is high from the third corner until its result sits in the output register
// synchronous reset clears the corner count, the sequencer and out_valid
module triangle_tangent_basis (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ttb_pkg::PosW-1:0]   pos_x,
  input  logic signed [ttb_pkg::PosW-1:0]   pos_y,
  input  logic signed [ttb_pkg::PosW-1:0]   pos_z,
  input  logic signed [ttb_pkg::TexW-1:0]   tex_u,
  input  logic signed [ttb_pkg::TexW-1:0]   tex_v,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ttb_pkg::OutW-1:0]   tangent_x,
  output logic signed [ttb_pkg::OutW-1:0]   tangent_y,
  output logic signed [ttb_pkg::OutW-1:0]   tangent_z,
  output logic signed [ttb_pkg::OutW-1:0]   bitangent_x,
  output logic signed [ttb_pkg::OutW-1:0]   bitangent_y,
  output logic signed [ttb_pkg::OutW-1:0]   bitangent_z,
  output logic                              degenerate,
  output logic                              clipped
);
  import ttb_pkg::*;

  ttb_state_t state, state_next;

  // held corners
  logic signed [PosW-1:0]   p1 [NumAxis];
  logic signed [PosW-1:0]   p2 [NumAxis];
  logic signed [TexW-1:0]   t1u, t1v, t2u, t2v;
  logic [1:0]               ccount;

  // triangle edges and uv deltas
  logic signed [EdgeW-1:0]  e1 [NumAxis];
  logic signed [EdgeW-1:0]  e2 [NumAxis];
  logic signed [DeltaW-1:0] d1u, d1v, d2u, d2v;

  // sequencer
  logic                     phase_det;
  logic [1:0]               axis;
  logic                     bt;
  logic [CntW-1:0]          cnt;

  // shared multiplier and accumulator
  logic signed [EdgeW-1:0]  mul_a;
  logic signed [DeltaW-1:0] mul_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [AccW-1:0]   acc;

  // divider
  logic                     det_neg;
  logic [DsorW-1:0]         dsor;
  logic [DivdW-1:0]         divd;
  logic [DsorW-1:0]         rem;
  logic [QuoW-1:0]          quo;
  logic                     neg;
  logic                     ovf;
  logic [DsorW:0]           r2;
  logic                     ge;
  logic [AccW-1:0]          nmag;
  logic [OutW-1:0]          res_val;
  logic                     res_clip;

  // per-triangle results
  logic signed [OutW-1:0]   tan_r [NumAxis];
  logic signed [OutW-1:0]   bit_r [NumAxis];
  logic                     clip_r;
  logic                     degen_r;

  logic                     in_acc;
  logic                     load_ok;

  // outputs of the sequencer
  always_comb begin
    in_stall = (state != S_IDLE);
    load_ok  = !out_valid || !out_stall;
    in_acc   = in_valid && (state == S_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    if (phase_det) begin
      if (state == S_MUL0) begin
        mul_a = EdgeW'(d1u);
        mul_b = d2v;
      end else begin
        mul_a = EdgeW'(d1v);
        mul_b = d2u;
      end
    end else if (!bt) begin
      if (state == S_MUL0) begin
        mul_a = e1[axis];
        mul_b = d2v;
      end else begin
        mul_a = e2[axis];
        mul_b = d1v;
      end
    end else begin
      if (state == S_MUL0) begin
        mul_a = e2[axis];
        mul_b = d1u;
      end else begin
        mul_a = e1[axis];
        mul_b = d2u;
      end
    end
    r2   = {rem, quo[QuoW-1]};
    ge   = (r2 >= {1'b0, dsor});
    nmag = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
    if (ovf || quo[QuoW-1] || (quo[OutW-1] && !(neg && quo[OutW-2:0] == '0))) begin
      res_clip = 1'b1;
      res_val  = neg ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
    end else begin
      res_clip = 1'b0;
      res_val  = neg ? OutW'(-quo[OutW-1:0]) : quo[OutW-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_acc && ccount == 2'd2) state_next = S_MUL0;
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_EVAL;
      S_EVAL: begin
        if (!phase_det)    state_next = S_PREP;
        else if (acc == '0) state_next = S_LOAD;
        else               state_next = S_MUL0;
      end
      S_PREP: state_next = S_CHK;
      S_CHK:  state_next = (HiW'(divd >> QuoW) >= dsor) ? S_FIN : S_DIV;
      S_DIV:  if (cnt == CntW'(QuoW - 1)) state_next = S_FIN;
      S_FIN:  state_next = (bt && axis == 2'(NumAxis - 1)) ? S_LOAD : S_MUL0;
      S_LOAD: if (load_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ccount    <= '0;
      out_valid <= 1'b0;
      phase_det <= 1'b0;
      axis      <= '0;
      bt        <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (state == S_LOAD && load_ok) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (in_acc) begin
        ccount <= (ccount == 2'd2) ? 2'd0 : ccount + 2'd1;
        if (ccount == 2'd2) begin
          phase_det <= 1'b1;
          axis      <= '0;
          bt        <= 1'b0;
        end
      end
      if (state == S_EVAL && phase_det && acc != '0) phase_det <= 1'b0;
      if (state == S_CHK) cnt <= '0;
      if (state == S_DIV) cnt <= cnt + CntW'(1);
      if (state == S_FIN) begin
        if (axis == 2'(NumAxis - 1)) begin
          axis <= '0;
          bt   <= 1'b1;
        end else begin
          axis <= axis + 2'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (ccount)
        2'd0: begin
          p1[0] <= pos_x;
          p1[1] <= pos_y;
          p1[2] <= pos_z;
          t1u   <= tex_u;
          t1v   <= tex_v;
        end
        2'd1: begin
          p2[0] <= pos_x;
          p2[1] <= pos_y;
          p2[2] <= pos_z;
          t2u   <= tex_u;
          t2v   <= tex_v;
        end
        default: begin
          for (int i = 0; i < NumAxis; i++) begin
            e1[i] <= EdgeW'(p2[i]) - EdgeW'(p1[i]);
          end
          e2[0]   <= EdgeW'(pos_x) - EdgeW'(p1[0]);
          e2[1]   <= EdgeW'(pos_y) - EdgeW'(p1[1]);
          e2[2]   <= EdgeW'(pos_z) - EdgeW'(p1[2]);
          d1u     <= DeltaW'(t2u) - DeltaW'(t1u);
          d1v     <= DeltaW'(t2v) - DeltaW'(t1v);
          d2u     <= DeltaW'(tex_u) - DeltaW'(t1u);
          d2v     <= DeltaW'(tex_v) - DeltaW'(t1v);
          clip_r  <= 1'b0;
          degen_r <= 1'b0;
        end
      endcase
    end
    case (state)
      S_MUL0: prod <= mul_a * mul_b;
      S_MUL1: begin
        acc  <= AccW'(prod);
        prod <= mul_a * mul_b;
      end
      S_MUL2: acc <= acc - AccW'(prod);
      S_EVAL: begin
        if (phase_det) begin
          if (acc == '0) begin
            degen_r <= 1'b1;
          end else begin
            det_neg <= acc[AccW-1];
            dsor    <= {nmag, 1'b0};
          end
        end
      end
      S_PREP: begin
        neg  <= acc[AccW-1] ^ det_neg;
        divd <= {1'b0, nmag, {FracSh{1'b0}}} + DivdW'(dsor[DsorW-1:1]);
      end
      S_CHK: begin
        ovf <= (HiW'(divd >> QuoW) >= dsor);
        rem <= DsorW'(divd >> QuoW);
        quo <= divd[QuoW-1:0];
      end
      S_DIV: begin
        rem <= ge ? DsorW'(r2 - {1'b0, dsor}) : DsorW'(r2);
        quo <= {quo[QuoW-2:0], ge};
      end
      S_FIN: begin
        if (bt) bit_r[axis] <= res_val;
        else    tan_r[axis] <= res_val;
        if (res_clip) clip_r <= 1'b1;
      end
      S_LOAD: begin
        if (load_ok) begin
          degenerate  <= degen_r;
          clipped     <= degen_r ? 1'b0 : clip_r;
          tangent_x   <= degen_r ? '0 : tan_r[0];
          tangent_y   <= degen_r ? '0 : tan_r[1];
          tangent_z   <= degen_r ? '0 : tan_r[2];
          bitangent_x <= degen_r ? '0 : bit_r[0];
          bitangent_y <= degen_r ? '0 : bit_r[1];
          bitangent_z <= degen_r ? '0 : bit_r[2];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // corner count never reaches three
  a_ccount: assert property (@(posedge clk) disable iff (rst) ccount != 2'd3)
    else $error("corner count out of range");

  // remainder stays below the divisor during the divide loop
  a_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < dsor)
    else $error("divider remainder not reduced");

  // a new result only appears after the load state
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_LOAD))
    else $error("result without load");

  // degenerate result carries zero vectors and no clip
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !clipped && tangent_x == '0 && bitangent_z == '0)
    else $error("degenerate result not cleared");
`endif

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ttb_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 400;

  // one result transfer
  typedef struct packed {
    logic [OutW-1:0] tx, ty, tz;
    logic [OutW-1:0] bx, by, bz;
    logic            degen;
    logic            clip;
  } basis_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [PosW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [TexW-1:0] tex_u = '0, tex_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OutW-1:0] tangent_x, tangent_y, tangent_z;
  logic signed [OutW-1:0] bitangent_x, bitangent_y, bitangent_z;
  logic degenerate, clipped;

  triangle_tangent_basis u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .tex_u      (tex_u),
    .tex_v      (tex_v),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .tangent_x  (tangent_x),
    .tangent_y  (tangent_y),
    .tangent_z  (tangent_z),
    .bitangent_x(bitangent_x),
    .bitangent_y(bitangent_y),
    .bitangent_z(bitangent_z),
    .degenerate (degenerate),
    .clipped    (clipped)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: held corners, sign-extended
  longint held_pos [2][NumAxis];
  longint held_tex [2][2];
  int     held_count;

  basis_t expected_bases[$];
  bit     idle_on = 1'b1;
  int     errors;
  int     corners_sent;
  int     bases_checked;
  int     degen_seen;
  int     clip_seen;
  int     quiet_cycles;

  // rounded (ties away from zero), saturated Q16.16 quotient num * 2^16 / den
  function automatic logic [OutW-1:0] round_quot(logic signed [127:0] num,
                                                 logic signed [127:0] den,
                                                 inout bit clip);
    logic [127:0] mag_n, mag_d, q;
    bit neg;
    neg   = num[127] ^ den[127];
    mag_n = num[127] ? -num : num;
    mag_d = den[127] ? -den : den;
    q     = ((mag_n << 17) + mag_d) / (mag_d << 1);
    if (q <= 128'h7FFF_FFFF) return neg ? -q[OutW-1:0] : q[OutW-1:0];
    if (neg && q == 128'h8000_0000) return 32'h8000_0000;
    clip = 1'b1;
    return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // advance the corner model by one accepted corner
  task automatic track_corner(longint p[NumAxis], longint t[2]);
    logic signed [127:0] e1, e2, d1u, d1v, d2u, d2v, det, tn, bn;
    logic [OutW-1:0] tq [NumAxis];
    logic [OutW-1:0] bq [NumAxis];
    basis_t b;
    bit clip;
    if (held_count < 2) begin
      held_pos[held_count] = p;
      held_tex[held_count] = t;
      held_count++;
      return;
    end
    held_count = 0;
    clip = 1'b0;
    d1u = held_tex[1][0] - held_tex[0][0];
    d1v = held_tex[1][1] - held_tex[0][1];
    d2u = t[0] - held_tex[0][0];
    d2v = t[1] - held_tex[0][1];
    det = d1u * d2v - d1v * d2u;
    b = '0;
    if (det == 0) begin
      b.degen = 1'b1;
    end else begin
      for (int i = 0; i < NumAxis; i++) begin
        e1 = held_pos[1][i] - held_pos[0][i];
        e2 = p[i] - held_pos[0][i];
        tn = e1 * d2v - e2 * d1v;
        bn = e2 * d1u - e1 * d2u;
        tq[i] = round_quot(tn, det, clip);
        bq[i] = round_quot(bn, det, clip);
      end
      b.tx = tq[0]; b.ty = tq[1]; b.tz = tq[2];
      b.bx = bq[0]; b.by = bq[1]; b.bz = bq[2];
      b.clip = clip;
    end
    expected_bases = {expected_bases, b};
  endtask

  // drive one corner and hold it until the transfer happens
  task automatic send_corner(logic [PosW-1:0] px, logic [PosW-1:0] py,
                             logic [PosW-1:0] pz, logic [TexW-1:0] tu,
                             logic [TexW-1:0] tv);
    longint p[NumAxis];
    longint t[2];
    int gap;
    gap = (idle_on && $urandom_range(99) < 30) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    tex_u <= tu; tex_v <= tv;
    do @(posedge clk); while (in_stall);
    p[0] = longint'($signed(px)); p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    t[0] = longint'($signed(tu)); t[1] = longint'($signed(tv));
    track_corner(p, t);
    corners_sent++;
  endtask

  task automatic send_triangle(logic [PosW-1:0] p[9], logic [TexW-1:0] t[6]);
    for (int k = 0; k < 3; k++)
      send_corner(p[3*k], p[3*k+1], p[3*k+2], t[2*k], t[2*k+1]);
  endtask

  // output side: random stall, compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 30);
    if (!rst && out_valid && !out_stall) begin
      basis_t got, want;
      got = '{tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z,
              degenerate, clipped};
      if (expected_bases.size() == 0) begin
        $display("%0t: result transfer with none expected: %p", $time, got);
        errors++;
      end else begin
        want = expected_bases.pop_front();
        bases_checked++;
        if (want.degen) degen_seen++;
        if (want.clip) clip_seen++;
        if (got.tx !== want.tx) begin
          $display("%0t: tangent_x exp %h got %h", $time, want.tx, got.tx); errors++;
        end
        if (got.ty !== want.ty) begin
          $display("%0t: tangent_y exp %h got %h", $time, want.ty, got.ty); errors++;
        end
        if (got.tz !== want.tz) begin
          $display("%0t: tangent_z exp %h got %h", $time, want.tz, got.tz); errors++;
        end
        if (got.bx !== want.bx) begin
          $display("%0t: bitangent_x exp %h got %h", $time, want.bx, got.bx); errors++;
        end
        if (got.by !== want.by) begin
          $display("%0t: bitangent_y exp %h got %h", $time, want.by, got.by); errors++;
        end
        if (got.bz !== want.bz) begin
          $display("%0t: bitangent_z exp %h got %h", $time, want.bz, got.bz); errors++;
        end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate exp %b got %b", $time, want.degen, got.degen); errors++;
        end
        if (got.clip !== want.clip) begin
          $display("%0t: clipped exp %b got %b", $time, want.clip, got.clip); errors++;
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_bases.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // corners at the field extremes
  task automatic test_extremes();
    send_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 24'h80_0000, 24'h7F_FFFF);
    send_corner(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 24'h7F_FFFF, 24'h80_0000);
    send_corner(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 24'h80_0000, 24'h80_0000);
    send_corner(32'h0, 32'h0, 32'h0, 24'h0, 24'h0);
    send_corner(32'h0001_0000, 32'h0, 32'h0, 24'h01_0000, 24'h0);
    send_corner(32'h0, 32'h0001_0000, 32'h0, 24'h0, 24'h01_0000);
    send_corner(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h7F_FFFF, 24'h7F_FFFF);
    send_corner(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h80_0000, 24'h7F_FFFF);
    send_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'h7F_FFFF, 24'h80_0000);
  endtask

  // zero determinant: repeated and collinear texture coordinates
  task automatic test_degenerate();
    send_corner(32'h1234_5678, 32'h0, 32'h0, 24'h00_1000, 24'h00_2000);
    send_corner(32'h0, 32'h1, 32'h2, 24'h00_1000, 24'h00_2000);
    send_corner(32'h3, 32'h4, 32'h5, 24'h00_1000, 24'h00_2000);
    send_corner(32'h0, 32'h0, 32'h0, 24'h0, 24'h0);
    send_corner(32'h7FFF_FFFF, 32'h0, 32'h0, 24'h00_0001, 24'h00_0002);
    send_corner(32'h8000_0000, 32'h0, 32'h0, 24'h00_0002, 24'h00_0004);
  endtask

  // tiny uv area with huge edges: every component saturates, both signs
  task automatic test_saturation();
    send_corner(32'h0, 32'h0, 32'h0, 24'h0, 24'h0);
    send_corner(32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0000, 24'h1, 24'h0);
    send_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000, 24'h0, 24'h1);
  endtask

  // uv edges (1,0) and (0,2^17) halve the bitangent: odd edges hit exact ties
  task automatic test_rounding();
    send_corner(32'h0, 32'h0, 32'h0, 24'h0, 24'h0);
    send_corner(32'h5, 32'hFFFF_FFFB, 32'h0, 24'h1, 24'h0);
    send_corner(32'h3, 32'hFFFF_FFFD, 32'h1, 24'h0, 24'h02_0000);
  endtask

  // random triangles with mixed content scales, some with degenerate uv coordinates
  task automatic test_random_triangles(int count);
    logic [PosW-1:0] p[9];
    logic [TexW-1:0] t[6];
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(9);
      for (int k = 0; k < 9; k++)
        p[k] = (kind < 3) ? $urandom() : PosW'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      for (int k = 0; k < 6; k++)
        t[k] = (kind < 3) ? TexW'($urandom())
                          : TexW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      if (kind == 9) begin
        // shared texture coordinate on all corners
        t[2] = t[0]; t[3] = t[1]; t[4] = t[0]; t[5] = t[1];
      end else if (kind == 8) begin
        // scaled uv edges, collinear
        t[4] = TexW'(t[0] + 2 * (t[2] - t[0]));
        t[5] = TexW'(t[1] + 2 * (t[3] - t[1]));
      end
      send_triangle(p, t);
      if (n == count / 2) idle_on = 1'b0;
      if (n == count / 2 + 60) idle_on = 1'b1;
    end
  endtask

  initial begin
    held_count = 0;
    errors = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_degenerate();
    test_saturation();
    test_rounding();
    test_random_triangles(300);
    in_valid <= 1'b0;
    while (expected_bases.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d corners, %0d triangles checked", corners_sent, bases_checked);
    $display("including %0d degenerate and %0d saturated results", degen_seen, clip_seen);
    if (errors == 0 && held_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
